[src/pwmicm_pkg.sv]
// ----------------------------------------------------------------------------
// PWM input capture meter package
// Shared widths, operation codes, status codes and the job handed from front
// to back.
// ----------------------------------------------------------------------------
`default_nettype none
package pwmicm_pkg;

    localparam int CAPTURE_WIDTH  = 16;
    localparam int OVERFLOW_WIDTH = 16;

    localparam logic [1:0] OP_OVERFLOW = 2'd0;
    localparam logic [1:0] OP_EDGE     = 2'd1;
    localparam logic [1:0] OP_REQUEST  = 2'd2;
    localparam logic [1:0] OP_TICK     = 2'd3;

    localparam logic [1:0] ST_MEASURED = 2'd0;
    localparam logic [1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [1:0] ST_ZERO     = 2'd2;

    localparam logic [0:0] CFG_TIMEOUT = 1'b0;
    localparam logic [0:0] CFG_TPS     = 1'b1;

    // high plus low span, each up to overflows:capture bits
    localparam int SPAN_W = CAPTURE_WIDTH + OVERFLOW_WIDTH + 1;

    // Job for the back end: a measured period or a fallback answer
    typedef struct packed {
        logic              fallback;
        logic              pin;
        logic [SPAN_W-1:0] high_ticks;
        logic [SPAN_W-1:0] period_ticks;
        logic [23:0]       tps;
    } job_t;

endpackage
`default_nettype wire

[src/pwmicm_front.sv]
// ----------------------------------------------------------------------------
// PWM input capture meter front end
// Tracks capture phases, overflow counts and the pending request; emits jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module pwmicm_front (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [1:0]                           op,
    input  wire logic [pwmicm_pkg::CAPTURE_WIDTH-1:0] cap,
    input  wire logic                                 rising,
    input  wire logic                                 pin,
    input  wire logic [31:0]                          timeout_us,
    input  wire logic [23:0]                          tps,
    output pwmicm_pkg::job_t                          job,
    output logic                                      job_valid,
    input  wire logic                                 job_ready
);
    localparam int CAPTURE_WIDTH  = pwmicm_pkg::CAPTURE_WIDTH;
    localparam int OVERFLOW_WIDTH = pwmicm_pkg::OVERFLOW_WIDTH;
    localparam int SW = pwmicm_pkg::SPAN_W;
    localparam int DW = CAPTURE_WIDTH + OVERFLOW_WIDTH;

    typedef enum logic [3:0] {
        PH_FIRST_RISE = 4'b0001,
        PH_FALL       = 4'b0010,
        PH_END_RISE   = 4'b0100,
        PH_HELD       = 4'b1000
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [CAPTURE_WIDTH-1:0]  rise_reg, rise_next, fall_reg, fall_next, end_reg, end_next;
    logic [OVERFLOW_WIDTH-1:0] run_reg, run_next, hov_reg, hov_next, lov_reg, lov_next;
    logic                      wait_reg, wait_next;
    logic [31:0]               cnt_reg, cnt_next;
    logic                      emit, emit_fb;
    logic [DW:0]               hi_d, lo_d, per_d;

    function automatic logic [DW:0] span(input logic [CAPTURE_WIDTH-1:0] a,
                                          input logic [CAPTURE_WIDTH-1:0] b,
                                          input logic [OVERFLOW_WIDTH-1:0] ov);
        logic [DW:0] d;
        d = {1'b0, ov, b} - {{(OVERFLOW_WIDTH+1){1'b0}}, a};
        if (ov == '0) d = {{(OVERFLOW_WIDTH+1){1'b0}}, b - a};
        return d;
    endfunction

    assign in_ready = job_ready;
    assign hi_d  = span(rise_reg, fall_reg, hov_reg);
    assign lo_d  = span(fall_reg, end_next, lov_next);
    assign per_d = hi_d + lo_d;

    always_comb begin
        phase_next = phase_reg; rise_next = rise_reg; fall_next = fall_reg;
        end_next = end_reg; run_next = run_reg; hov_next = hov_reg; lov_next = lov_reg;
        wait_next = wait_reg; cnt_next = cnt_reg; emit = 1'b0; emit_fb = 1'b0;
        if (in_valid && in_ready) begin
            unique case (op)
                pwmicm_pkg::OP_OVERFLOW: run_next = run_reg + 1'b1;
                pwmicm_pkg::OP_EDGE: begin
                    if (phase_reg == PH_FIRST_RISE && rising) begin
                        run_next = '0; rise_next = cap; phase_next = PH_FALL;
                    end else if (phase_reg == PH_FALL && !rising) begin
                        fall_next = cap; hov_next = run_reg; run_next = '0;
                        phase_next = PH_END_RISE;
                    end else if (phase_reg == PH_END_RISE && rising) begin
                        end_next = cap; lov_next = run_reg; run_next = '0;
                        phase_next = PH_HELD;
                        emit = wait_reg;
                    end
                end
                pwmicm_pkg::OP_REQUEST: begin
                    if (phase_reg == PH_HELD) emit = 1'b1;
                    else if (timeout_us == '0) emit_fb = 1'b1;
                    else begin
                        wait_next = 1'b1; cnt_next = '0;
                    end
                end
                default: begin
                    if (wait_reg) begin
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_next >= timeout_us) emit_fb = 1'b1;
                    end
                end
            endcase
            if (emit) begin
                phase_next = PH_FALL; run_next = '0; rise_next = end_next;
            end
            if (emit || emit_fb) begin
                wait_next = 1'b0; cnt_next = '0;
            end
        end
    end

    always_comb begin
        job_valid        = emit || emit_fb;
        job.fallback     = emit_fb;
        job.pin          = pin;
        job.high_ticks   = SW'(hi_d);
        job.period_ticks = SW'(per_d);
        job.tps          = tps;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST_RISE; rise_reg <= '0; fall_reg <= '0; end_reg <= '0;
            run_reg <= '0; hov_reg <= '0; lov_reg <= '0; wait_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            phase_reg <= phase_next; rise_reg <= rise_next; fall_reg <= fall_next;
            end_reg <= end_next; run_reg <= run_next; hov_reg <= hov_next;
            lov_reg <= lov_next; wait_reg <= wait_next; cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

[src/pwmicm_queue.sv]
// ----------------------------------------------------------------------------
// PWM input capture meter job queue
// Two-entry FIFO between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
module pwmicm_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire pwmicm_pkg::job_t in_job,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output pwmicm_pkg::job_t      out_job,
    output logic                  out_valid,
    input  wire logic             out_ready
);
    pwmicm_pkg::job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_job   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

[src/pwmicm_back.sv]
// ----------------------------------------------------------------------------
// PWM input capture meter back end
// Restoring divider computes frequency and duty, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pwmicm_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire pwmicm_pkg::job_t job,
    input  wire logic             job_valid,
    output logic                  job_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [23:0]           m_frequency_hz,
    output logic [6:0]            m_duty_percent,
    output logic [1:0]            m_status
);
    localparam int SW = pwmicm_pkg::SPAN_W;
    localparam int NW = SW + 7;  // room for 100 * high

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_FREQ = 4'b0010, S_DUTY = 4'b0100, S_OUT = 4'b1000
    } state_t;

    state_t         st_reg, st_next;
    logic [NW-1:0]  num_reg, num_next;
    logic [NW-1:0]  rem_reg, rem_next;
    logic [SW-1:0]  div_reg, div_next;
    logic [5:0]     bit_reg, bit_next;
    logic [23:0]    freq_reg, freq_next;
    logic [6:0]     duty_reg, duty_next;
    logic [1:0]     stat_reg, stat_next;
    logic [SW-1:0]  hi_hold;
    logic [NW-1:0]  trial;
    logic           ge;

    assign job_ready      = st_reg == S_IDLE;
    assign m_valid        = st_reg == S_OUT;
    assign m_frequency_hz = freq_reg;
    assign m_duty_percent = duty_reg;
    assign m_status       = stat_reg;
    assign trial = {rem_reg[NW-2:0], num_reg[NW-1]};
    assign ge    = trial >= {{(NW-SW){1'b0}}, div_reg};

    always_comb begin
        st_next = st_reg; num_next = num_reg; rem_next = rem_reg; div_next = div_reg;
        bit_next = bit_reg; freq_next = freq_reg; duty_next = duty_reg;
        stat_next = stat_reg;
        unique case (st_reg) inside
            S_IDLE: begin
                if (job_valid) begin
                    if (job.fallback) begin
                        freq_next = '0;
                        duty_next = job.pin ? 7'd100 : 7'd0;
                        stat_next = pwmicm_pkg::ST_TIMEOUT;
                        st_next = S_OUT;
                    end else if (job.period_ticks == '0) begin
                        freq_next = '0; duty_next = '0;
                        stat_next = pwmicm_pkg::ST_ZERO;
                        st_next = S_OUT;
                    end else begin
                        stat_next = pwmicm_pkg::ST_MEASURED;
                        div_next = job.period_ticks;
                        num_next = NW'(job.tps);
                        rem_next = '0;
                        bit_next = 6'(NW - 1);
                        // high time is held aside for the duty division
                        duty_next = '0;
                        freq_next = '0;
                        st_next = S_FREQ;
                    end
                end
            end
            S_FREQ, S_DUTY: begin
                num_next = {num_reg[NW-2:0], ge};
                rem_next = ge ? trial - {{(NW-SW){1'b0}}, div_reg} : trial;
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0) begin
                    if (st_reg == S_FREQ) begin
                        freq_next = num_next[23:0];
                        num_next = ({{(NW-SW){1'b0}}, hi_hold} << 6)
                                 + ({{(NW-SW){1'b0}}, hi_hold} << 5)
                                 + ({{(NW-SW){1'b0}}, hi_hold} << 2);
                        rem_next = '0;
                        bit_next = 6'(NW - 1);
                        st_next = S_DUTY;
                    end else begin
                        duty_next = num_next[6:0];
                        st_next = S_OUT;
                    end
                end
            end
            default: if (m_ready) st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (st_reg == S_IDLE && job_valid) hi_hold <= job.high_ticks;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= S_IDLE;
        else st_reg <= st_next;
        num_reg <= num_next; rem_reg <= rem_next; div_reg <= div_next;
        bit_reg <= bit_next; freq_reg <= freq_next; duty_reg <= duty_next;
        stat_reg <= stat_next;
    end
endmodule
`default_nettype wire

[src/pwm_input_capture_meter.sv]
// A fallback or zero-period answer is offered once its job has passed the
// job queue into the back end; a measured one follows two 40-step restoring
// divisions, one quotient bit a cycle, in the back end.
// Throughput: events are taken one a cycle while the two-entry job queue has
// room; the back end takes a new job only after its last answer is accepted.
// Reset clears all capture state, loads timeout_us 1000, ticks_per_second 1e6.
// ----------------------------------------------------------------------------
// PWM input capture meter
// Measures PWM frequency and duty from timer capture events.
// ----------------------------------------------------------------------------
`default_nettype none
module pwm_input_capture_meter (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [1:0]                           s_operation,
    input  wire logic [pwmicm_pkg::CAPTURE_WIDTH-1:0] s_capture_value,
    input  wire logic                                 s_edge_rising,
    input  wire logic                                 s_pin_level,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [23:0]                               m_frequency_hz,
    output logic [6:0]                                m_duty_percent,
    output logic [1:0]                                m_status,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [0:0]                           cfg_index,
    input  wire logic [31:0]                          cfg_data
);
    logic [31:0] timeout_reg;
    logic [23:0] tps_reg;
    pwmicm_pkg::job_t fj, bj;
    logic fv, fr, bv, br;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= 32'd1000; tps_reg <= 24'd1000000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pwmicm_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data;
                default: tps_reg <= cfg_data[23:0];
            endcase
        end
    end

    pwmicm_front u_front (
        .aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready), .op(s_operation),
        .cap(s_capture_value), .rising(s_edge_rising), .pin(s_pin_level),
        .timeout_us(timeout_reg), .tps(tps_reg), .job(fj), .job_valid(fv), .job_ready(fr)
    );
    pwmicm_queue u_queue (
        .aclk, .aresetn, .in_job(fj), .in_valid(fv), .in_ready(fr),
        .out_job(bj), .out_valid(bv), .out_ready(br)
    );
    pwmicm_back u_back (
        .aclk, .aresetn, .job(bj), .job_valid(bv), .job_ready(br),
        .m_valid, .m_ready, .m_frequency_hz, .m_duty_percent, .m_status
    );
endmodule
`default_nettype wire

[dv/tb_pwm_input_capture_meter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM input capture meter testbench
// Drives timer events (overflows, edge captures, measure requests and
// microsecond ticks) under random flow control and checks every answer
// against an in-bench model of the capture sequence and the timeout logic.
// Runs directed tables, then random traffic under several register settings.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_pwm_input_capture_meter;

    localparam logic [1:0] OP_OVERFLOW = pwmicm_pkg::OP_OVERFLOW;
    localparam logic [1:0] OP_EDGE     = pwmicm_pkg::OP_EDGE;
    localparam logic [1:0] OP_REQUEST  = pwmicm_pkg::OP_REQUEST;
    localparam logic [1:0] OP_TICK     = pwmicm_pkg::OP_TICK;
    localparam logic [1:0] ST_MEASURED = pwmicm_pkg::ST_MEASURED;
    localparam logic [1:0] ST_TIMEOUT  = pwmicm_pkg::ST_TIMEOUT;
    localparam logic [1:0] ST_ZERO     = pwmicm_pkg::ST_ZERO;
    localparam logic [0:0] CFG_TIMEOUT = pwmicm_pkg::CFG_TIMEOUT;
    localparam logic [0:0] CFG_TPS     = pwmicm_pkg::CFG_TPS;

    localparam int SETTLE_CYCLES = 120;
    localparam int STALL_LIMIT   = 6000;

    typedef struct packed {
        logic [23:0] freq;
        logic [6:0]  duty;
        logic [1:0]  status;
    } answer_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] cap;
        logic        rise;
        logic        pin;
        logic        typed;
        answer_t     ans;
    } event_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = OP_OVERFLOW;
    logic [15:0] s_capture_value = '0;
    logic        s_edge_rising = 1'b0;
    logic        s_pin_level = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_frequency_hz;
    logic [6:0]  m_duty_percent;
    logic [1:0]  m_status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = CFG_TIMEOUT;
    logic [31:0] cfg_data = '0;

    always #4 aclk = ~aclk;

    pwm_input_capture_meter dut (.*);

    // meter model state
    logic [31:0] mdl_timeout;
    logic [23:0] mdl_tps;
    logic [1:0]  mdl_phase;
    logic [15:0] mdl_rise, mdl_fall, mdl_end;
    logic [15:0] mdl_run_ovf, mdl_high_ovf, mdl_low_ovf;
    logic        mdl_waiting;
    logic [31:0] mdl_wait_cnt;

    answer_t     pending_answers[$];
    int          err_count = 0;
    int          items_sent = 0;
    int          answers_seen = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    logic [15:0] last_cap = '0;
    logic        rx_hold = 1'b0;
    int          n_measured = 0, n_timeout = 0, n_zero = 0;

    function automatic logic [63:0] tick_span(logic [15:0] from, logic [15:0] to,
                                              logic [15:0] ovf);
        logic [63:0] d;
        d = ({48'd0, ovf} << 16) + {48'd0, to} - {48'd0, from};
        if (ovf == 0 && to < from)
            d = {48'd0, to - from};
        return d;
    endfunction

    function automatic answer_t close_period();
        logic [63:0] hi, lo, per;
        answer_t a;
        hi  = tick_span(mdl_rise, mdl_fall, mdl_high_ovf);
        lo  = tick_span(mdl_fall, mdl_end, mdl_low_ovf);
        per = hi + lo;
        if (per == 0) begin
            a = '{24'd0, 7'd0, ST_ZERO};
        end else begin
            a.freq   = 24'({40'd0, mdl_tps} / per);
            a.duty   = 7'((hi * 100) / per);
            a.status = ST_MEASURED;
        end
        mdl_phase    = 2'd1;
        mdl_run_ovf  = '0;
        mdl_rise     = mdl_end;
        mdl_waiting  = 1'b0;
        mdl_wait_cnt = '0;
        return a;
    endfunction

    function automatic answer_t give_up(logic pin);
        mdl_waiting  = 1'b0;
        mdl_wait_cnt = '0;
        return '{24'd0, pin ? 7'd100 : 7'd0, ST_TIMEOUT};
    endfunction

    // advance the meter model by one event; returns 1 when an answer comes out
    function automatic bit meter_step(logic [1:0] op, logic [15:0] cap, logic rise,
                                      logic pin, output answer_t a);
        a = '0;
        case (op)
            OP_OVERFLOW: begin
                mdl_run_ovf = mdl_run_ovf + 1'b1;
            end
            OP_EDGE: begin
                if (mdl_phase == 0 && rise) begin
                    mdl_run_ovf = '0;
                    mdl_rise    = cap;
                    mdl_phase   = 2'd1;
                end else if (mdl_phase == 1 && !rise) begin
                    mdl_fall     = cap;
                    mdl_high_ovf = mdl_run_ovf;
                    mdl_run_ovf  = '0;
                    mdl_phase    = 2'd2;
                end else if (mdl_phase == 2 && rise) begin
                    mdl_end     = cap;
                    mdl_low_ovf = mdl_run_ovf;
                    mdl_run_ovf = '0;
                    mdl_phase   = 2'd3;
                    if (mdl_waiting) begin
                        a = close_period();
                        return 1'b1;
                    end
                end
            end
            OP_REQUEST: begin
                if (mdl_phase == 3) begin
                    a = close_period();
                    return 1'b1;
                end
                if (mdl_timeout == 0) begin
                    a = give_up(pin);
                    return 1'b1;
                end
                mdl_waiting  = 1'b1;
                mdl_wait_cnt = '0;
            end
            default: begin
                if (mdl_waiting) begin
                    mdl_wait_cnt = mdl_wait_cnt + 1;
                    if (mdl_wait_cnt >= mdl_timeout) begin
                        a = give_up(pin);
                        return 1'b1;
                    end
                end
            end
        endcase
        return 1'b0;
    endfunction

    // offer one event, hold it until taken, then queue the answer it causes
    task automatic send_event(event_row_t row);
        answer_t a;
        bit      has_ans;
        if (burst_left == 0) begin
            if (s_valid) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                      : $urandom_range(5, 60);
        end
        burst_left--;
        s_valid         <= 1'b1;
        s_operation     <= row.op;
        s_capture_value <= row.cap;
        s_edge_rising   <= row.rise;
        s_pin_level     <= row.pin;
        do @(posedge aclk); while (!s_ready);
        has_ans = meter_step(row.op, row.cap, row.rise, row.pin, a);
        if (row.typed)
            pending_answers.push_back(row.ans);
        else if (has_ans)
            pending_answers.push_back(a);
        items_sent++;
        last_cap = row.cap;
    endtask

    task automatic drain();
        if (s_valid) s_valid <= 1'b0;
        burst_left = 0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_TIMEOUT) mdl_timeout = value;
        else mdl_tps = value[23:0];
        @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_cap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return last_cap;
        if (r < 17) return 16'h0000;
        if (r < 22) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // mostly well-formed capture sequences, some noise
    function automatic event_row_t random_event();
        event_row_t e;
        int r;
        e = '0;
        e.cap = pick_cap();
        e.pin = $urandom_range(0, 1);
        e.rise = $urandom_range(0, 1);
        r = $urandom_range(0, 99);
        if (r < 12) begin
            e.op = 2'($urandom_range(0, 3));
        end else if (r < 35) begin
            e.op = OP_OVERFLOW;
        end else if (r < 50) begin
            e.op = OP_TICK;
        end else if (r < 60) begin
            e.op = OP_REQUEST;
        end else if (mdl_phase == 3) begin
            e.op = OP_REQUEST;
        end else begin
            e.op   = OP_EDGE;
            e.rise = (mdl_phase != 1);
        end
        return e;
    endfunction

    localparam event_row_t RESET_ROWS [0:17] = '{
        '{OP_REQUEST,  16'h0000, 1'b0, 1'b1, 1'b0, '0},
        '{OP_EDGE,     16'h0064, 1'b0, 1'b0, 1'b0, '0},  // wrong polarity
        '{OP_EDGE,     16'h0064, 1'b1, 1'b0, 1'b0, '0},
        '{OP_EDGE,     16'h0064, 1'b1, 1'b0, 1'b0, '0},  // wrong polarity
        '{OP_EDGE,     16'h0064, 1'b0, 1'b0, 1'b0, '0},
        '{OP_EDGE,     16'h0064, 1'b1, 1'b0, 1'b1, '{24'd0, 7'd0, ST_ZERO}},
        '{OP_REQUEST,  16'h0000, 1'b0, 1'b0, 1'b0, '0},
        '{OP_REQUEST,  16'h0000, 1'b0, 1'b0, 1'b0, '0},  // restart the wait
        '{OP_EDGE,     16'h0000, 1'b0, 1'b0, 1'b0, '0},  // below start, no overflow
        '{OP_EDGE,     16'hFFFF, 1'b1, 1'b1, 1'b0, '0},
        '{OP_TICK,     16'h0000, 1'b0, 1'b1, 1'b0, '0},  // nothing waiting
        '{OP_EDGE,     16'h1234, 1'b1, 1'b0, 1'b0, '0},  // wrong polarity
        '{OP_OVERFLOW, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
        '{OP_REQUEST,  16'h0000, 1'b0, 1'b0, 1'b0, '0},
        '{OP_OVERFLOW, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
        '{OP_EDGE,     16'hFFFF, 1'b0, 1'b0, 1'b0, '0},
        '{OP_OVERFLOW, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
        '{OP_EDGE,     16'h0000, 1'b1, 1'b1, 1'b0, '0}
    };

    localparam event_row_t NO_WAIT_ROWS [0:3] = '{
        '{OP_REQUEST, 16'h0000, 1'b0, 1'b1, 1'b1, '{24'd0, 7'd100, ST_TIMEOUT}},
        '{OP_REQUEST, 16'hFFFF, 1'b1, 1'b0, 1'b1, '{24'd0, 7'd0, ST_TIMEOUT}},
        '{OP_TICK,    16'h0000, 1'b0, 1'b1, 1'b0, '0},
        '{OP_EDGE,    16'hABCD, 1'b1, 1'b0, 1'b0, '0}
    };

    // receiver: stall pattern switches between modes, or holds off on request
    int rx_mode = 0;
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) rx_mode <= $urandom_range(0, 3);
        if (rx_hold)           m_ready <= 1'b0;
        else if (rx_mode == 0) m_ready <= 1'b1;
        else if (rx_mode == 1) m_ready <= ($urandom_range(0, 3) != 0);
        else if (rx_mode == 2) m_ready <= ($urandom_range(0, 3) == 0);
        else                   m_ready <= ($urandom_range(0, 19) == 0);
    end

    always @(posedge aclk) begin
        answer_t want;
        if (m_valid && m_ready) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
                $error("answer with none expected: freq %0d duty %0d status %0d",
                       m_frequency_hz, m_duty_percent, m_status);
                err_count++;
            end else begin
                want = pending_answers.pop_front();
                case (want.status)
                    ST_MEASURED: n_measured++;
                    ST_TIMEOUT:  n_timeout++;
                    default:     n_zero++;
                endcase
                if (m_frequency_hz !== want.freq) begin
                    $error("frequency_hz: expected %0d, got %0d", want.freq, m_frequency_hz);
                    err_count++;
                end
                if (m_duty_percent !== want.duty) begin
                    $error("duty_percent: expected %0d, got %0d", want.duty, m_duty_percent);
                    err_count++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    err_count++;
                end
            end
        end
    end

    // watchdog on any handshake activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress, %0d answers outstanding",
                     pending_answers.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [31:0] timeouts [0:5];
        logic [23:0] rates    [0:5];
        mdl_timeout = 32'd1000; mdl_tps = 24'd1000000;
        mdl_phase = '0; mdl_rise = '0; mdl_fall = '0; mdl_end = '0;
        mdl_run_ovf = '0; mdl_high_ovf = '0; mdl_low_ovf = '0;
        mdl_waiting = 1'b0; mdl_wait_cnt = '0;
        timeouts = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd7, 32'd25, 32'd3};
        rates    = '{24'd16000000, 24'd1, 24'd1000000, 24'd48000, 24'd16000000, 24'd777};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (RESET_ROWS[i]) send_event(RESET_ROWS[i]);
        drain();
        write_reg(CFG_TIMEOUT, 32'd0);
        foreach (NO_WAIT_ROWS[i]) send_event(NO_WAIT_ROWS[i]);

        for (int p = 0; p < 6; p++) begin
            drain();
            write_reg(CFG_TIMEOUT, (p == 4) ? $urandom_range(2, 40) : timeouts[p]);
            write_reg(CFG_TPS, {8'd0, rates[p]});
            if (p == 0) begin
                // hold the receiver off while requests keep coming
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (1500) @(posedge aclk);
                        rx_hold = 1'b0;
                    end
                    begin
                        for (int k = 0; k < 120; k++)
                            send_event('{OP_REQUEST, 16'($urandom), 1'b0,
                                         1'($urandom), 1'b0, '0});
                    end
                join
            end
            for (int k = 0; k < 170; k++) begin
                if (k == 85) drain();  // pause until everything has come back
                send_event(random_event());
            end
        end

        drain();
        $display("sent %0d events, checked %0d answers", items_sent, answers_seen);
        $display("measured %0d, timed out %0d, zero period %0d",
                 n_measured, n_timeout, n_zero);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
